// File: hw/rtl/bflc_pkg.sv
// ----------------------------------------------------------------------------
// bflc_pkg: shared definitions for the brightness level fade controller
// Command and status codes, register indexes, field widths and the
// level-to-raw brightness table.
// ----------------------------------------------------------------------------
package bflc_pkg;

  // Field widths
  localparam int KIND_W     = 3;
  localparam int LEVEL_W    = 4;
  localparam int RAW_W      = 8;
  localparam int DUR_W      = 16;
  localparam int ELAPSED_W  = 17;
  localparam int PERIOD_W   = 10;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Fade interpolation divide: (raw difference * elapsed) / duration
  localparam int DIVIDEND_W = RAW_W + DUR_W;
  localparam int DIVISOR_W  = DUR_W;

  localparam int DEFAULT_MAX_LEVEL = 10;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX    = '1;
  localparam logic [PERIOD_W-1:0]  PERIOD_RESET   = PERIOD_W'(50);
  localparam logic [LEVEL_W-1:0]   LEVEL_RESET    = LEVEL_W'(10);
  localparam logic [RAW_W-1:0]     RAW_RESET      = 8'hFF;

  // Command kinds
  localparam logic [KIND_W-1:0] KIND_SET_LEVEL = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SET_RAW   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FADE      = 3'd2;
  localparam logic [KIND_W-1:0] KIND_STOP      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TICK      = 3'd4;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DISABLED = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL_ENABLED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD   = 2'd1;

  // Level to raw panel byte; levels past the last entry use the last entry
  function automatic logic [RAW_W-1:0] table_raw(input logic [LEVEL_W-1:0] lvl);
    logic [RAW_W-1:0] r;
    unique case (lvl)
      4'd0:    r = 8'h00;
      4'd1:    r = 8'h0D;
      4'd2:    r = 8'h33;
      4'd3:    r = 8'h7F;
      4'd4:    r = 8'hAC;
      4'd5:    r = 8'hCC;
      4'd6:    r = 8'hD9;
      4'd7:    r = 8'hE6;
      4'd8:    r = 8'hF2;
      4'd9:    r = 8'hF9;
      default: r = 8'hFF;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/brightness_level_fade_controller_unit.sv
// ----------------------------------------------------------------------------
// brightness_level_fade_controller_unit: backlight level and fade control
// Set level, set raw, linear fade and stop commands plus a millisecond tick
// that advances a running fade; one result transfer per set level, set raw,
// fade or stop command and per fade update.
// ----------------------------------------------------------------------------
// The block takes one command at a time and drops in_ready until its result
// has been loaded into the output register. Set level, fade, stop, rejected
// commands and ticks that finish a fade go from decode straight to the
// result step; ticks with no result return to idle from decode. Set raw
// first searches the table, probing at most MAX_LEVEL + 1 entries. A fade
// update tick that interpolates passes through a multiply step and the
// serial 24-bit by 16-bit divider, which produces one quotient bit per
// cycle. A result that is not taken holds in the output register while the
// next command is accepted and processed; that command then waits for the
// register to drain. Configuration writes are always accepted and must only
// be issued while the block is idle. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module brightness_level_fade_controller_unit import bflc_pkg::*; #(
  parameter int MAX_LEVEL = DEFAULT_MAX_LEVEL
) (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [KIND_W-1:0]     kind,
  input  logic [LEVEL_W-1:0]    level,
  input  logic [RAW_W-1:0]      raw_value,
  input  logic [DUR_W-1:0]      fade_ms,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic                  drive_write,
  output logic [RAW_W-1:0]      drive_raw,
  output logic [LEVEL_W-1:0]    level_now,
  output logic                  fade_active,
  // configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SRCH_W = $clog2(MAX_LEVEL + 1);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DECODE = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_EMIT   = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration
  logic                  control_enabled;
  logic [PERIOD_W-1:0]   update_period_ms;
  logic [PERIOD_W-1:0]   period_eff;

  // latched command
  logic [KIND_W-1:0]     cmd_kind;
  logic [LEVEL_W-1:0]    cmd_level;
  logic [RAW_W-1:0]      cmd_raw;
  logic [DUR_W-1:0]      cmd_duration;

  // architectural state
  logic [LEVEL_W-1:0]    stored_level, stored_level_next;
  logic [RAW_W-1:0]      stored_raw, stored_raw_next;
  logic                  fading, fading_next;
  logic [LEVEL_W-1:0]    fade_target, fade_target_next;
  logic [DUR_W-1:0]      fade_duration, fade_duration_next;
  logic [ELAPSED_W-1:0]  elapsed_ms, elapsed_ms_next;
  logic [PERIOD_W-1:0]   period_count, period_count_next;

  // pending result
  logic [STATUS_W-1:0]   res_status, res_status_next;
  logic                  res_write, res_write_next;
  logic [RAW_W-1:0]      res_raw, res_raw_next;

  // work registers
  logic [SRCH_W-1:0]     search_idx, search_idx_next;
  logic                  fade_up, fade_up_next;
  logic [DIVIDEND_W-1:0] prod, prod_next;
  logic                  div_start, div_start_next;

  // decode helpers
  logic                  level_bad;
  logic [ELAPSED_W-1:0]  elapsed_inc;
  logic [PERIOD_W-1:0]   period_inc;
  logic [RAW_W-1:0]      goal_raw;
  logic [RAW_W-1:0]      raw_diff;
  logic [RAW_W-1:0]      probe_raw;
  logic                  out_load;

  logic                  div_done;
  logic [DIVIDEND_W-1:0] div_quotient;

  assign in_ready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign period_eff = (update_period_ms == '0) ? PERIOD_W'(1) : update_period_ms;
  assign level_bad  = (cmd_level > LEVEL_W'(MAX_LEVEL));
  assign elapsed_inc = (elapsed_ms != ELAPSED_MAX) ? elapsed_ms + 1'b1 : elapsed_ms;
  assign period_inc  = period_count + 1'b1;
  assign goal_raw    = table_raw(fade_target);
  assign raw_diff    = (goal_raw >= stored_raw) ? goal_raw - stored_raw
                                                : stored_raw - goal_raw;
  assign probe_raw   = table_raw(LEVEL_W'(search_idx));
  // load the output register once the previous result has drained
  assign out_load    = (state == ST_EMIT) && (!out_valid || out_ready);

  // Divider for fade interpolation
  bflc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (fade_duration),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer
  always_comb begin
    state_next         = state;
    stored_level_next  = stored_level;
    stored_raw_next    = stored_raw;
    fading_next        = fading;
    fade_target_next   = fade_target;
    fade_duration_next = fade_duration;
    elapsed_ms_next    = elapsed_ms;
    period_count_next  = period_count;
    res_status_next    = res_status;
    res_write_next     = res_write;
    res_raw_next       = res_raw;
    search_idx_next    = search_idx;
    fade_up_next       = fade_up;
    prod_next          = prod;
    div_start_next     = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end

      ST_DECODE: begin
        // default: reject-style result that reports the stored raw value
        res_status_next = STATUS_OK;
        res_write_next  = 1'b0;
        res_raw_next    = stored_raw;
        state_next      = ST_EMIT;
        unique case (cmd_kind)
          KIND_SET_LEVEL: begin
            if (level_bad) begin
              res_status_next = STATUS_INVALID;
            end else if (!control_enabled) begin
              res_status_next = STATUS_DISABLED;
            end else begin
              fading_next       = 1'b0;
              stored_level_next = cmd_level;
              stored_raw_next   = table_raw(cmd_level);
              res_write_next    = 1'b1;
              res_raw_next      = table_raw(cmd_level);
            end
          end
          KIND_SET_RAW: begin
            if (!control_enabled) begin
              res_status_next = STATUS_DISABLED;
            end else begin
              search_idx_next = '0;
              state_next      = ST_SEARCH;
            end
          end
          KIND_FADE: begin
            if (level_bad) begin
              res_status_next = STATUS_INVALID;
            end else if (!control_enabled) begin
              res_status_next = STATUS_DISABLED;
            end else if (fading && (fade_target == cmd_level)) begin
              // same target while fading: ignore
              res_status_next = STATUS_OK;
            end else if (cmd_duration == '0) begin
              fading_next       = 1'b0;
              stored_level_next = cmd_level;
              stored_raw_next   = table_raw(cmd_level);
              res_write_next    = 1'b1;
              res_raw_next      = table_raw(cmd_level);
            end else begin
              // restart the fade from the stored raw value
              fade_target_next   = cmd_level;
              fade_duration_next = cmd_duration;
              elapsed_ms_next    = '0;
              period_count_next  = '0;
              fading_next        = 1'b1;
              res_write_next     = 1'b1;
            end
          end
          KIND_STOP: begin
            if (!control_enabled) begin
              res_status_next = STATUS_DISABLED;
            end else begin
              fading_next = 1'b0;
            end
          end
          KIND_TICK: begin
            if (!control_enabled || !fading) begin
              state_next = ST_IDLE;
            end else begin
              elapsed_ms_next = elapsed_inc;
              if (period_inc < period_eff) begin
                period_count_next = period_inc;
                state_next        = ST_IDLE;
              end else begin
                period_count_next = '0;
                if (elapsed_inc >= {1'b0, fade_duration}) begin
                  // fade complete: land on the target level
                  fading_next       = 1'b0;
                  stored_level_next = fade_target;
                  stored_raw_next   = goal_raw;
                  res_write_next    = 1'b1;
                  res_raw_next      = goal_raw;
                end else begin
                  state_next = ST_MUL;
                end
              end
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end

      ST_SEARCH: begin
        // first level whose table entry reaches the raw value, else MAX_LEVEL
        if ((probe_raw >= cmd_raw) || (search_idx == SRCH_W'(MAX_LEVEL))) begin
          fading_next       = 1'b0;
          stored_raw_next   = cmd_raw;
          stored_level_next = LEVEL_W'(search_idx);
          res_status_next   = STATUS_OK;
          res_write_next    = 1'b1;
          res_raw_next      = cmd_raw;
          state_next        = ST_EMIT;
        end else begin
          search_idx_next = search_idx + 1'b1;
        end
      end

      ST_MUL: begin
        // elapsed is below the duration here, so it fits the low 16 bits
        fade_up_next   = (goal_raw >= stored_raw);
        prod_next      = DIVIDEND_W'(raw_diff) * DIVIDEND_W'(elapsed_ms[DUR_W-1:0]);
        div_start_next = 1'b1;
        state_next     = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          res_status_next = STATUS_OK;
          res_write_next  = 1'b1;
          res_raw_next    = fade_up ? stored_raw + div_quotient[RAW_W-1:0]
                                    : stored_raw - div_quotient[RAW_W-1:0];
          state_next      = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      control_enabled  <= 1'b1;
      update_period_ms <= PERIOD_RESET;
      stored_level     <= LEVEL_RESET;
      stored_raw       <= RAW_RESET;
      fading           <= 1'b0;
      fade_target      <= '0;
      fade_duration    <= '0;
      elapsed_ms       <= '0;
      period_count     <= '0;
      div_start        <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      state         <= state_next;
      stored_level  <= stored_level_next;
      stored_raw    <= stored_raw_next;
      fading        <= fading_next;
      fade_target   <= fade_target_next;
      fade_duration <= fade_duration_next;
      elapsed_ms    <= elapsed_ms_next;
      period_count  <= period_count_next;
      div_start     <= div_start_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CONTROL_ENABLED) begin
          control_enabled <= cfg_data[0];
        end else if (cfg_index == REG_UPDATE_PERIOD) begin
          update_period_ms <= cfg_data[PERIOD_W-1:0];
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_kind     <= kind;
      cmd_level    <= level;
      cmd_raw      <= raw_value;
      cmd_duration <= fade_ms;
    end
    res_status <= res_status_next;
    res_write  <= res_write_next;
    res_raw    <= res_raw_next;
    search_idx <= search_idx_next;
    fade_up    <= fade_up_next;
    prod       <= prod_next;
    if (out_load) begin
      status      <= res_status;
      drive_write <= res_write;
      drive_raw   <= res_raw;
      level_now   <= stored_level;
      fade_active <= fading;
    end
  end

  // Checks
  a_fade_target_ok: assert property (@(posedge clk) disable iff (rst)
    fading |-> (fade_target <= LEVEL_W'(MAX_LEVEL)) && (fade_duration != '0))
    else $error("fade running with bad target or zero duration");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divide step");

  a_emit_fills_output: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |=> out_valid)
    else $error("result step left the output register empty");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("command accepted while busy");

endmodule

// File: hw/rtl/bflc_div.sv
// ----------------------------------------------------------------------------
// bflc_div: serial restoring divider
// One quotient bit per cycle; done is raised by the edge that registers the last bit.
// ----------------------------------------------------------------------------
module bflc_div import bflc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy;
  logic [CNT_W-1:0]      count;
  logic [DIVIDEND_W-1:0] quo;
  logic [DIVIDEND_W-1:0] quo_next;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  rem_next;
  logic [DIVISOR_W-1:0]  dvs;
  logic [DIVISOR_W:0]    rem_shift;

  always_comb begin
    rem_shift = {rem, quo[DIVIDEND_W-1]};
    if (rem_shift >= {1'b0, dvs}) begin
      rem_next = DIVISOR_W'(rem_shift - {1'b0, dvs});
      quo_next = {quo[DIVIDEND_W-2:0], 1'b1};
    end else begin
      rem_next = rem_shift[DIVISOR_W-1:0];
      quo_next = {quo[DIVIDEND_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(DIVIDEND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the brightness level fade controller
// Drives set level, set raw, fade, stop and millisecond tick commands over
// the command channel, predicts every panel drive result from a behavioral
// copy of the controller state, and checks results in order. Directed corner
// cases come first, then random fade runs under several idle and stall
// patterns and register settings.
// ----------------------------------------------------------------------------
module testbench;
  import bflc_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 6;
  // Longest quiet stretch: set raw probes the whole table, or a divide runs
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_500_000;
  localparam int BLOCKS        = 12;
  localparam int BLOCK_ITEMS   = 35;
  localparam int SLOW_PERIOD   = 100;
  localparam int SLOW_FADE_MS  = 150;

  // Update period per random block; zero checks the treated-as-one rule
  localparam int unsigned PERIOD_CHOICES [BLOCKS] = '{1, 2, 3, 1, 5, 2, 0, 7, 1, 4, 2, 1};
  // Block run with the controller switched off
  localparam int OFF_BLOCK = 5;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_kind_t;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [LEVEL_W-1:0] level;
    logic [RAW_W-1:0]   raw;
    logic [DUR_W-1:0]   dur;
  } command_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                drv_write;
    logic [RAW_W-1:0]    drv_raw;
    logic [LEVEL_W-1:0]  level;
    logic                fading;
  } drive_t;

  // Tracks controller state, predicts panel drives and checks them in order
  class brightness_scoreboard;
    drive_t                drives_due[$];
    int unsigned           errors;
    bit                    enabled;
    logic [PERIOD_W-1:0]   period;
    logic [LEVEL_W-1:0]    cur_level;
    logic [RAW_W-1:0]      cur_raw;
    bit                    fading;
    logic [LEVEL_W-1:0]    target;
    logic [DUR_W-1:0]      fade_len;
    logic [ELAPSED_W-1:0]  elapsed;
    logic [PERIOD_W-1:0]   ticks_in_period;

    function new();
      errors          = 0;
      enabled         = 1'b1;
      period          = PERIOD_RESET;
      cur_level       = LEVEL_RESET;
      cur_raw         = RAW_RESET;
      fading          = 1'b0;
      target          = '0;
      fade_len        = '0;
      elapsed         = '0;
      ticks_in_period = '0;
    endfunction

    static function logic [RAW_W-1:0] level_raw(int unsigned lvl);
      logic [RAW_W-1:0] steps [0:10];
      steps = '{8'h00, 8'h0D, 8'h33, 8'h7F, 8'hAC, 8'hCC, 8'hD9, 8'hE6, 8'hF2, 8'hF9, 8'hFF};
      return (lvl > 10) ? steps[10] : steps[lvl];
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_CONTROL_ENABLED) enabled = data[0];
      else if (idx == REG_UPDATE_PERIOD) period = data[PERIOD_W-1:0];
    endfunction

    function void settle_level(logic [LEVEL_W-1:0] lvl);
      fading    = 1'b0;
      cur_level = lvl;
      cur_raw   = level_raw(lvl);
    endfunction

    // Advance the model by one accepted command; queue its drive if it has one
    function void take_command(command_t c);
      drive_t           d;
      bit               emits;
      bit               stepped;
      logic [RAW_W-1:0] goal;
      logic [RAW_W-1:0] mid;
      int unsigned      span;
      int unsigned      period_eff;
      emits       = 1'b1;
      stepped     = 1'b0;
      mid         = '0;
      d.status    = STATUS_OK;
      d.drv_write = 1'b0;
      case (c.kind)
        KIND_SET_LEVEL: begin
          if (c.level > DEFAULT_MAX_LEVEL) d.status = STATUS_INVALID;
          else if (!enabled) d.status = STATUS_DISABLED;
          else begin
            settle_level(c.level);
            d.drv_write = 1'b1;
          end
        end
        KIND_SET_RAW: begin
          if (!enabled) d.status = STATUS_DISABLED;
          else begin
            fading    = 1'b0;
            cur_raw   = c.raw;
            cur_level = LEVEL_W'(DEFAULT_MAX_LEVEL);
            // scan downward so the lowest matching level wins
            for (int i = DEFAULT_MAX_LEVEL; i >= 0; i--) begin
              if (level_raw(i) >= c.raw) cur_level = LEVEL_W'(i);
            end
            d.drv_write = 1'b1;
          end
        end
        KIND_FADE: begin
          if (c.level > DEFAULT_MAX_LEVEL) d.status = STATUS_INVALID;
          else if (!enabled) d.status = STATUS_DISABLED;
          else if (fading && target == c.level) d.drv_write = 1'b0;
          else if (c.dur == '0) begin
            settle_level(c.level);
            d.drv_write = 1'b1;
          end else begin
            target          = c.level;
            fade_len        = c.dur;
            elapsed         = '0;
            ticks_in_period = '0;
            fading          = 1'b1;
            d.drv_write     = 1'b1;
          end
        end
        KIND_STOP: begin
          if (!enabled) d.status = STATUS_DISABLED;
          else fading = 1'b0;
        end
        KIND_TICK: begin
          emits = 1'b0;
          if (enabled && fading) begin
            period_eff = (period == '0) ? 1 : period;
            if (elapsed != ELAPSED_MAX) elapsed++;
            ticks_in_period++;
            if (ticks_in_period >= period_eff) begin
              ticks_in_period = '0;
              emits           = 1'b1;
              d.drv_write     = 1'b1;
              if (elapsed >= fade_len) settle_level(target);
              else begin
                // interpolate from the stored raw value, which stays put
                goal    = level_raw(target);
                stepped = 1'b1;
                if (goal >= cur_raw) begin
                  span = ((32'(goal) - 32'(cur_raw)) * 32'(elapsed)) / 32'(fade_len);
                  mid  = cur_raw + RAW_W'(span);
                end else begin
                  span = ((32'(cur_raw) - 32'(goal)) * 32'(elapsed)) / 32'(fade_len);
                  mid  = cur_raw - RAW_W'(span);
                end
              end
            end
          end
        end
        default: emits = 1'b0;
      endcase
      d.drv_raw = stepped ? mid : cur_raw;
      d.level   = cur_level;
      d.fading  = fading;
      if (emits) drives_due.push_back(d);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_drive(drive_t got);
      drive_t want;
      if (drives_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, got);
        errors++;
        return;
      end
      want = drives_due.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("drive_write", want.drv_write, got.drv_write);
      compare_field("drive_raw", want.drv_raw, got.drv_raw);
      compare_field("level_now", want.level, got.level);
      compare_field("fade_active", want.fading, got.fading);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     kind = '0;
  logic [LEVEL_W-1:0]    level = '0;
  logic [RAW_W-1:0]      raw_value = '0;
  logic [DUR_W-1:0]      fade_ms = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic                  drive_write;
  logic [RAW_W-1:0]      drive_raw;
  logic [LEVEL_W-1:0]    level_now;
  logic                  fade_active;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  brightness_scoreboard sb = new();
  idle_kind_t           idle_mode = IDLE_NONE;
  int unsigned          sent = 0;
  int unsigned          cycle_count = 0;

  brightness_level_fade_controller_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .level      (level),
    .raw_value  (raw_value),
    .fade_ms    (fade_ms),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .drive_write(drive_write),
    .drive_raw  (drive_raw),
    .level_now  (level_now),
    .fade_active(fade_active),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  // Receiver: stall at random in the phases that call for it, else always take
  always @(posedge clk) begin
    case (idle_mode)
      IDLE_RECEIVER: out_ready <= ($urandom_range(99) >= 78);
      IDLE_BOTH:     out_ready <= ($urandom_range(99) >= 13);
      default:       out_ready <= 1'b1;
    endcase
  end

  // Check every result transfer against the oldest predicted drive
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_drive(drive_t'{status, drive_write, drive_raw, level_now, fade_active});
  end

  // Watchdog: end the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("simulation failed");
    $finish;
  end

  // Present one command, hold it until the transfer, then update the model.
  // Leaves in_valid high so back-to-back commands never toggle it in one step.
  task automatic send_command(int unsigned k, int unsigned l, int unsigned r, int unsigned d);
    command_t    c;
    int unsigned gap_pct;
    c.kind  = KIND_W'(k);
    c.level = LEVEL_W'(l);
    c.raw   = RAW_W'(r);
    c.dur   = DUR_W'(d);
    gap_pct = (idle_mode == IDLE_BOTH) ? 13 : 78;
    while ((idle_mode == IDLE_SENDER || idle_mode == IDLE_BOTH) &&
           $urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= c.kind;
    level     <= c.level;
    raw_value <= c.raw;
    fade_ms   <= c.dur;
    do @(posedge clk); while (!in_ready);
    sb.take_command(c);
    sent++;
  endtask

  // Hold off the sender until every predicted drive has come back, then let
  // any result-free tick still in flight finish
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (sb.drives_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers back to back; call only with the block quiet
  task automatic set_config(bit en, int unsigned per);
    cfg_valid <= 1'b1;
    cfg_index <= REG_CONTROL_ENABLED;
    cfg_data  <= CFG_DATA_W'(en);
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(REG_CONTROL_ENABLED, CFG_DATA_W'(en));
    cfg_index <= REG_UPDATE_PERIOD;
    cfg_data  <= CFG_DATA_W'(per);
    do @(posedge clk); while (!cfg_ready);
    sb.write_register(REG_UPDATE_PERIOD, CFG_DATA_W'(per));
    cfg_valid <= 1'b0;
  endtask

  // Start a fade sized to the current update period and tick it to the end,
  // with the odd command thrown in to cut across it
  task automatic fade_sequence();
    int unsigned pe;
    int unsigned dur;
    int unsigned tgt;
    int unsigned ticks;
    pe    = (sb.period == '0) ? 1 : sb.period;
    tgt   = $urandom_range(DEFAULT_MAX_LEVEL);
    dur   = $urandom_range(6 * pe, 1);
    ticks = dur + pe + $urandom_range(2);
    send_command(KIND_FADE, tgt, $urandom, dur);
    repeat (ticks) begin
      if ($urandom_range(99) < 5) begin
        case ($urandom_range(4))
          0: send_command(KIND_SET_LEVEL, $urandom_range(15), $urandom, $urandom);
          1: send_command(KIND_SET_RAW, $urandom, $urandom, $urandom);
          2: send_command(KIND_STOP, $urandom, $urandom, $urandom);
          3: send_command(KIND_FADE, tgt, $urandom, $urandom);
          default: send_command(KIND_FADE, $urandom_range(DEFAULT_MAX_LEVEL), $urandom,
                                $urandom_range(3 * pe));
        endcase
      end else begin
        send_command(KIND_TICK, $urandom, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Level and raw extremes, out-of-range levels, rounding of raw bytes
    send_command(KIND_SET_LEVEL, 0, 0, 0);
    send_command(KIND_SET_LEVEL, DEFAULT_MAX_LEVEL, 8'hFF, 16'hFFFF);
    send_command(KIND_SET_LEVEL, 15, 0, 0);
    send_command(KIND_SET_LEVEL, DEFAULT_MAX_LEVEL + 1, 0, 0);
    send_command(KIND_SET_RAW, 0, 8'h00, 0);
    send_command(KIND_SET_RAW, 15, 8'hFF, 0);
    // between table entries: round up to the next level
    send_command(KIND_SET_RAW, 0, 8'h80, 0);
    send_command(KIND_SET_RAW, 0, 8'h33, 0);
    send_command(KIND_FADE, DEFAULT_MAX_LEVEL + 2, 0, 10);
    // zero duration fade acts as set level
    send_command(KIND_FADE, 3, 0, 0);
    // stop and tick with nothing running
    send_command(KIND_STOP, 0, 0, 0);
    send_command(KIND_TICK, 0, 0, 0);
    // unused kinds are dropped without a result
    for (int k = KIND_TICK + 1; k < 2 ** KIND_W; k++) send_command(k, 15, 8'hFF, 16'hFFFF);
    // longest fade, then a fade to the same target that must be ignored
    send_command(KIND_FADE, 0, 0, 16'hFFFF);
    send_command(KIND_FADE, 0, 0, 100);
    repeat (3) send_command(KIND_TICK, 0, 0, 0);
    // a new target restarts the fade
    send_command(KIND_FADE, 9, 0, 3);
    send_command(KIND_STOP, 0, 0, 0);

    // Fastest updates: interpolate every tick, then finish at the target
    wait_quiet();
    set_config(1'b1, 1);
    send_command(KIND_FADE, DEFAULT_MAX_LEVEL, 0, 4);
    repeat (5) send_command(KIND_TICK, 0, 0, 0);

    // Switched off mid-fade: reject everything, freeze the fade counters
    send_command(KIND_FADE, 1, 0, 6);
    send_command(KIND_TICK, 0, 0, 0);
    wait_quiet();
    set_config(1'b0, 1);
    send_command(KIND_SET_LEVEL, DEFAULT_MAX_LEVEL + 3, 0, 0);
    send_command(KIND_FADE, DEFAULT_MAX_LEVEL + 4, 0, 5);
    send_command(KIND_SET_LEVEL, 2, 0, 0);
    send_command(KIND_SET_RAW, 0, 8'h44, 0);
    send_command(KIND_FADE, 5, 0, 5);
    send_command(KIND_STOP, 0, 0, 0);
    repeat (3) send_command(KIND_TICK, 0, 0, 0);
    // back on with a zero period, which behaves as one
    wait_quiet();
    set_config(1'b1, 0);
    repeat (8) send_command(KIND_TICK, 0, 0, 0);

    // Random blocks: mostly complete fades, some noise, rotating idle patterns
    for (int b = 0; b < BLOCKS; b++) begin
      int unsigned first;
      wait_quiet();
      idle_mode = idle_kind_t'(b % 4);
      set_config(b != OFF_BLOCK, PERIOD_CHOICES[b]);
      first = sent;
      while (sent - first < BLOCK_ITEMS) begin
        if ($urandom_range(99) < 75) fade_sequence();
        else send_command($urandom_range(2 ** KIND_W - 1), $urandom, $urandom, $urandom);
      end
    end

    // Long period: one interpolated update, then completion
    wait_quiet();
    idle_mode = IDLE_NONE;
    set_config(1'b1, SLOW_PERIOD);
    send_command(KIND_STOP, 0, 0, 0);
    send_command(KIND_FADE, $urandom_range(DEFAULT_MAX_LEVEL), 0, SLOW_FADE_MS);
    repeat (2 * SLOW_PERIOD + 1) send_command(KIND_TICK, $urandom, $urandom, $urandom);

    wait_quiet();
    if (sb.errors == 0 && sb.drives_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/bflc_pkg.sv
hw/rtl/bflc_div.sv
hw/rtl/brightness_level_fade_controller_unit.sv
tb/testbench.sv
